@@ rtl/mgt_pkg.sv @@
// Package for the masked grid triangulation block.
// Holds word types, register indexes, reset values and quad case codes.
// No dependencies; every other file of the block imports it.
package mgt_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int IDX_W     = 20;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 2;
    localparam int CODE_W    = 4;

    localparam int ROW_WIDTH_RST    = 640;
    localparam int FRAME_HEIGHT_RST = 480;
    localparam int DIM_MIN          = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CODE_W-1:0] CODE_MISS_P3 = 4'd7;
    localparam logic [CODE_W-1:0] CODE_MISS_P2 = 4'd11;
    localparam logic [CODE_W-1:0] CODE_MISS_P1 = 4'd13;
    localparam logic [CODE_W-1:0] CODE_MISS_P0 = 4'd14;
    localparam logic [CODE_W-1:0] CODE_FULL    = 4'd15;

    localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;

    typedef struct packed {
        logic mask_bit;
    } mask_word_t;

    typedef struct packed {
        logic [COUNT_W-1:0] triangle_count;
        logic [IDX_W-1:0]   first_tri_a;
        logic [IDX_W-1:0]   first_tri_b;
        logic [IDX_W-1:0]   first_tri_c;
        logic [IDX_W-1:0]   second_tri_a;
        logic [IDX_W-1:0]   second_tri_b;
        logic [IDX_W-1:0]   second_tri_c;
    } mesh_word_t;

endpackage

@@ rtl/mgt_if.sv @@
// Handshake interfaces for the masked grid triangulation block.
// Each carries valid, ready and a word (cfg an index and data); depends on mgt_pkg.
interface mgt_mask_if;
    import mgt_pkg::*;
    logic       valid;
    logic       ready;
    mask_word_t word;
    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

interface mgt_mesh_if;
    import mgt_pkg::*;
    logic       valid;
    logic       ready;
    mesh_word_t word;
    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

interface mgt_cfg_if;
    import mgt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/masked_grid_triangulation.sv @@
// Masked grid triangulation: turns a raster stream of mask bits into triangles.
// Depends on mgt_pkg and the interfaces in mgt_if.sv.
//
// The mask channel takes one mask bit per word in raster order. Each pixel past
// the first row and column closes a 2x2 quad with the line buffer, and a quad
// with three or four set bits yields one mesh word of one or two triangles,
// given as linear pixel indices. Other pixels yield no word.
// The cfg channel writes row_width (index 0) and frame_height (index 1); it is
// always ready and is meant to be used while the block is idle.
// A pixel is accepted in every cycle while mask ready is high.
// The line buffer is written at the current column and, in the same cycle,
// read one pixel ahead so the upper bit is ready when the next pixel arrives.
// The output register holds a word until it is taken; while it is held and not
// taken, mask ready drops. Reset clears the counters, left_reg, ul_reg and the
// output valid and sets the registers to 640 by 480. The line buffer is not
// cleared; the first row of each frame writes it before it is read.
module masked_grid_triangulation #(
    parameter int MAX_WIDTH  = mgt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mgt_pkg::MAX_HEIGHT_DEF
) (
    input logic         clk,
    input logic         rst_n,
    mgt_cfg_if.sink     cfg,
    mgt_mask_if.sink    mask,
    mgt_mesh_if.source  mesh
);
    import mgt_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam logic [WW-1:0] W_RST =
        WW'((ROW_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : ROW_WIDTH_RST);
    localparam logic [HW-1:0] H_RST =
        HW'((FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST);

    function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
        if (int'(v) < DIM_MIN)
            return WW'(DIM_MIN);
        if (int'(v) > MAX_WIDTH)
            return WW'(MAX_WIDTH);
        return WW'(v);
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
        if (int'(v) < DIM_MIN)
            return HW'(DIM_MIN);
        if (int'(v) > MAX_HEIGHT)
            return HW'(MAX_HEIGHT);
        return HW'(v);
    endfunction

    logic [WW-1:0]    w_reg;
    logic [HW-1:0]    h_reg;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [IDX_W-1:0] pix_reg, pix_next;
    logic             left_reg;
    logic             ul_reg;
    logic             up_reg;
    logic             line_mem [MAX_WIDTH];
    logic [CW-1:0]    rd_addr;
    logic             acc;
    logic             cur;
    logic             col_wrap;
    logic             row_wrap;
    logic [CODE_W-1:0] code;
    logic [IDX_W-1:0] p0, p1, p2, p3;
    mesh_word_t       tri_word;
    mesh_word_t       mesh_word_reg;
    logic             mesh_valid_reg, mesh_valid_next;

    assign cfg.ready  = 1'b1;
    assign mask.ready = !mesh_valid_reg || mesh.ready;
    assign acc        = mask.valid && mask.ready;
    assign cur        = mask.word.mask_bit;
    assign mesh.valid = mesh_valid_reg;
    assign mesh.word  = mesh_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= W_RST;
            h_reg <= H_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_ROW_WIDTH:    w_reg <= clamp_w(cfg.data);
                REG_FRAME_HEIGHT: h_reg <= clamp_h(cfg.data);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        col_wrap = (int'(col_reg) + 1) >= int'(w_reg);
        row_wrap = (int'(row_reg) + 1) >= int'(h_reg);
        pix_next = pix_reg + 1'b1;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            if (row_wrap)
            begin
                row_next = '0;
                pix_next = '0;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end
        else
        begin
            col_next = col_reg + 1'b1;
        end
        rd_addr = acc ? col_next : col_reg;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            line_mem[col_reg] <= cur;
        up_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pix_reg  <= '0;
            left_reg <= 1'b0;
            ul_reg   <= 1'b0;
        end
        else if (acc)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pix_reg  <= pix_next;
            left_reg <= cur;
            ul_reg   <= up_reg;
        end
    end

    always_comb
    begin
        p3   = pix_reg;
        p2   = pix_reg - 1'b1;
        p1   = pix_reg - IDX_W'(w_reg);
        p0   = pix_reg - IDX_W'(w_reg) - 1'b1;
        code = {cur, left_reg, up_reg, ul_reg};
        tri_word = '0;
        case (code)
            CODE_MISS_P3:
            begin
                tri_word.triangle_count = COUNT_ONE;
                tri_word.first_tri_a = p0;
                tri_word.first_tri_b = p2;
                tri_word.first_tri_c = p1;
            end
            CODE_MISS_P2:
            begin
                tri_word.triangle_count = COUNT_ONE;
                tri_word.first_tri_a = p0;
                tri_word.first_tri_b = p3;
                tri_word.first_tri_c = p1;
            end
            CODE_MISS_P1:
            begin
                tri_word.triangle_count = COUNT_ONE;
                tri_word.first_tri_a = p0;
                tri_word.first_tri_b = p2;
                tri_word.first_tri_c = p3;
            end
            CODE_MISS_P0:
            begin
                tri_word.triangle_count = COUNT_ONE;
                tri_word.first_tri_a = p1;
                tri_word.first_tri_b = p2;
                tri_word.first_tri_c = p3;
            end
            CODE_FULL:
            begin
                tri_word.triangle_count = COUNT_TWO;
                tri_word.first_tri_a  = p0;
                tri_word.first_tri_b  = p2;
                tri_word.first_tri_c  = p1;
                tri_word.second_tri_a = p2;
                tri_word.second_tri_b = p3;
                tri_word.second_tri_c = p1;
            end
            default: tri_word.triangle_count = COUNT_NONE;
        endcase
        if (col_reg == '0 || row_reg == '0)
            tri_word.triangle_count = COUNT_NONE;
    end

    always_comb
    begin
        mesh_valid_next = mesh_valid_reg;
        if (mesh.ready)
            mesh_valid_next = 1'b0;
        if (acc)
            mesh_valid_next = (tri_word.triangle_count != COUNT_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mesh_valid_reg <= 1'b0;
        else
            mesh_valid_reg <= mesh_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            mesh_word_reg <= tri_word;
    end

endmodule

@@ rtl/mgt_checker.sv @@
// Port-level checks for the masked grid triangulation block.
// Depends on mgt_pkg; bound to masked_grid_triangulation at the end of the file.
module mgt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         mask_valid,
    input logic                         mask_ready,
    input logic                         mesh_valid,
    input logic                         mesh_ready,
    input logic [mgt_pkg::COUNT_W-1:0]  triangle_count,
    input logic [mgt_pkg::IDX_W-1:0]    second_tri_a,
    input logic [mgt_pkg::IDX_W-1:0]    second_tri_b,
    input logic [mgt_pkg::IDX_W-1:0]    second_tri_c
);
    import mgt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        mesh_valid && !mesh_ready |=> mesh_valid)
        else $error("Mesh word dropped while stalled.");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        mesh_valid |-> (triangle_count == COUNT_ONE || triangle_count == COUNT_TWO))
        else $error("Mesh word with no triangle.");

    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        mesh_valid && triangle_count == COUNT_ONE |->
            (second_tri_a == '0 && second_tri_b == '0 && second_tri_c == '0))
        else $error("Second triangle not zero in a single-triangle word.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !mesh_valid || mesh_ready |-> mask_ready)
        else $error("Mask channel stalled with a free output register.");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mesh_valid) |-> $past(mask_valid && mask_ready))
        else $error("Mesh word without an accepted pixel.");

endmodule

bind masked_grid_triangulation mgt_checker u_mgt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .mask_valid     (mask.valid),
    .mask_ready     (mask.ready),
    .mesh_valid     (mesh.valid),
    .mesh_ready     (mesh.ready),
    .triangle_count (mesh.word.triangle_count),
    .second_tri_a   (mesh.word.second_tri_a),
    .second_tri_b   (mesh.word.second_tri_b),
    .second_tri_c   (mesh.word.second_tri_c)
);
